/* rtl/psu_pkg.sv */
// Shared types, Q2.30 constants and elaboration-time math for the sinc upsampler
`default_nettype none

package psu_pkg;

    // Width of the phase field on the result channel
    localparam int PHASE_BITS = 2;

    // Q2.30 constants used while building the kernel table
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam longint      INV_PI_Q30  = 64'sd341782638;
    localparam longint      C042_Q30    = 64'sd450971566;
    localparam longint      C008_Q30    = 64'sd85899346;

    // Control word that travels with each operand pair into the MAC
    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } t_mac_ctl;

    // Sign-magnitude Q30 product, rounded half up on the magnitude
    function automatic longint mul_q30(input longint a, input longint b);
        logic        neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] p;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = (ua * ub + (64'd1 << 29)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // Sine of x / 2^32 turns in Q30, odd Horner series on a quarter wave
    function automatic longint sin_turn(input logic [31:0] x);
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        q  = x[31:30];
        r  = {34'd0, x[29:0]};
        if (q[0]) begin
            r = 64'h4000_0000 - r;
        end
        a  = (r * HALF_PI_Q30) >> 30;
        a2 = (a * a) >> 30;
        t  = Q30_ONE - a2 / 64'd110;
        t  = Q30_ONE - ((a2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
        s  = (a * t) >> 30;
        return q[1] ? -longint'(s) : longint'(s);
    endfunction

endpackage

`default_nettype wire

/* rtl/psu_if.sv */
// Valid/ready channel interfaces for the upsampler's sample and result streams
`default_nettype none

interface psu_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          block_end;

    modport source (output valid, in_sample, block_end, input ready);
    modport sink   (input valid, in_sample, block_end, output ready);
endinterface

interface psu_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                               valid;
    logic                               ready;
    logic signed [SAMPLE_BITS-1:0]      out_sample;
    logic [psu_pkg::PHASE_BITS-1:0]     phase;
    logic                               run_last;
    logic                               output_block_end;

    modport source (output valid, out_sample, phase, run_last, output_block_end, input ready);
    modport sink   (input valid, out_sample, phase, run_last, output_block_end, output ready);
endinterface

`default_nettype wire

/* rtl/psu_mac.sv */
// Pipelined multiply-accumulate with round-half-up and saturation to the sample grid
`default_nettype none

module psu_mac #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18,
    parameter int KERNEL_TAPS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire psu_pkg::t_mac_ctl             i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [COEF_BITS-1:0]   i_coef,
    output logic                               o_done,
    output logic signed [SAMPLE_BITS-1:0]      o_result
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(KERNEL_TAPS);
    localparam int RND_W  = ACC_W + 1;
    localparam int FRAC   = COEF_BITS - 2;

    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'sd1 <<< (FRAC - 1));
    localparam logic signed [RND_W-1:0] SAT_MAX  =
        RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RND_W-1:0] SAT_MIN  =
        RND_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic signed [PROD_W-1:0]      r_prod;
    psu_pkg::t_mac_ctl             r_pc;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_ld;
    logic                          r_done;
    logic signed [SAMPLE_BITS-1:0] r_result;

    logic signed [RND_W-1:0]       rnd_sum;
    logic signed [RND_W-1:0]       rnd_q;
    logic signed [SAMPLE_BITS-1:0] n_result;

    // Round half up toward +inf, then clamp to the signed sample range
    assign rnd_sum = RND_W'(r_acc) + RND_HALF;
    assign rnd_q   = rnd_sum >>> FRAC;

    always_comb begin
        if (rnd_q > SAT_MAX) begin
            n_result = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (rnd_q < SAT_MIN) begin
            n_result = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            n_result = rnd_q[SAMPLE_BITS-1:0];
        end
    end

    // Multiply, accumulate, then register the rounded sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_ld   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_prod <= i_sample * i_coef;
            r_pc   <= i_ctl;
            if (r_pc.valid) begin
                r_acc <= (r_pc.clear ? '0 : r_acc) + ACC_W'(r_prod);
            end
            r_ld   <= r_pc.valid && r_pc.last;
            r_done <= r_ld;
            if (r_ld) begin
                r_result <= n_result;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/polyphase_sinc_upsampler_unit.sv */
// Polyphase windowed-sinc upsampler by UPSAMPLE_FACTOR (L) over a KERNEL_TAPS (K) window.
//
// Channels: i_in carries one sample and its block-end flag per request; o_out carries
// one result per request with its phase, a run-last flag and an output-block-end flag.
// Both use valid/ready; a request moves when valid and ready are high at a clock edge.
// The sample window lives in a K-entry synchronous memory; the kernels are a constant
// table built at elaboration. Each phase after phase 0 streams K memory reads through one
// multiplier, so the MAC loop over the window sets the rate.
// Results per input: none while the window is still filling, L once it is full, plus
// the trailing sample at a block end. With L=1 each sample passes straight through.
// i_in.ready is high only while the sequencer is idle. The last result of an input
// may still sit in the output register when the next sample is taken.
// Receiver stall: the result holds in the output register and the sequencer waits
// with the next one until the register frees.
// Reset (synchronous, active low) clears the write pointer, the fill count and the
// output register; the window memory is left as is and is refilled before it is read.
`default_nettype none

module polyphase_sinc_upsampler_unit #(
    parameter int UPSAMPLE_FACTOR = 4,
    parameter int KERNEL_TAPS     = 16,
    parameter int SAMPLE_BITS     = 24,
    parameter int COEF_BITS       = 18
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    psu_in_if.sink     i_in,
    psu_out_if.source  o_out
);

    localparam int PTR_W    = $clog2(KERNEL_TAPS);
    localparam int SUM_W    = PTR_W + 1;
    localparam int FILL_W   = $clog2(KERNEL_TAPS + 1);
    localparam int FULL_LEN = KERNEL_TAPS * UPSAMPLE_FACTOR;
    localparam int HALF_LEN = FULL_LEN / 2;
    localparam int DEN      = 2 * UPSAMPLE_FACTOR;
    localparam int CADDR_W  = $clog2(FULL_LEN);
    localparam int PH_W     = (UPSAMPLE_FACTOR > 1) ? $clog2(UPSAMPLE_FACTOR) : 1;
    localparam int CSH      = 32 - COEF_BITS;
    localparam longint CMAX = (64'sd1 <<< (COEF_BITS - 1)) - 64'sd1;

    typedef logic signed [COEF_BITS-1:0] t_coef_arr [FULL_LEN];

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RWAIT,
        S_MAC,
        S_DRAIN,
        S_PUSH
    } t_state;

    // Bit-serial unsigned divide, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Full kernel: sinc times Blackman window in Q2.30, rounded to COEF_BITS
    function automatic t_coef_arr build_rom();
        t_coef_arr   rom;
        longint      m;
        longint      s;
        longint      num;
        longint      sinc;
        longint      c1;
        longint      c2;
        longint      w;
        longint      c;
        longint      val;
        logic [63:0] um;
        logic [63:0] x;
        logic [63:0] x1;
        logic [63:0] x2;
        logic [63:0] un;
        logic [63:0] uq;
        logic [63:0] mag;
        for (int t = 0; t < FULL_LEN; t++) begin
            m  = longint'(t) - longint'(HALF_LEN);
            um = (m < 0) ? -m : m;
            if (um == 64'd0) begin
                sinc = longint'(psu_pkg::Q30_ONE);
            end else begin
                x    = (((um % DEN) << 32) + 64'(UPSAMPLE_FACTOR)) / DEN;
                s    = psu_pkg::sin_turn(x[31:0]);
                num  = s * UPSAMPLE_FACTOR;
                un   = (num < 0) ? -num : num;
                uq   = udiv64(un, um);
                sinc = psu_pkg::mul_q30((num < 0) ? -longint'(uq) : longint'(uq),
                                        psu_pkg::INV_PI_Q30);
            end
            x1  = ((64'(t) << 32) + 64'(HALF_LEN)) / FULL_LEN;
            x2  = (((64'(2 * t) % FULL_LEN) << 32) + 64'(HALF_LEN)) / FULL_LEN;
            c1  = psu_pkg::sin_turn(32'(x1 + 64'h4000_0000));
            c2  = psu_pkg::sin_turn(32'(x2 + 64'h4000_0000));
            w   = psu_pkg::C042_Q30 - c1 / 2 + psu_pkg::mul_q30(psu_pkg::C008_Q30, c2);
            c   = psu_pkg::mul_q30(sinc, w);
            mag = (c < 0) ? -c : c;
            mag = (mag + (64'd1 << (CSH - 1))) >> CSH;
            val = (c < 0) ? -longint'(mag) : longint'(mag);
            if (val > CMAX) begin
                val = CMAX;
            end
            if (val < -CMAX - 1) begin
                val = -CMAX - 1;
            end
            rom[t] = COEF_BITS'(val);
        end
        return rom;
    endfunction

    localparam t_coef_arr COEF_ROM = build_rom();

    // Circular add on a window pointer
    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W-1:0] p,
                                                  input int unsigned off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, p} + SUM_W'(off);
        if (sum >= SUM_W'(KERNEL_TAPS)) begin
            sum = sum - SUM_W'(KERNEL_TAPS);
        end
        return sum[PTR_W-1:0];
    endfunction

    t_state                        r_state;
    logic [PTR_W-1:0]              r_wp;
    logic [FILL_W-1:0]             r_fill;
    logic [PH_W-1:0]               r_ph;
    logic                          r_trail;
    logic                          r_res_last;
    logic                          r_res_obe;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic [PTR_W-1:0]              r_dir_addr;
    logic [PTR_W-1:0]              r_rp;
    logic [CADDR_W-1:0]            r_caddr;
    logic [PTR_W-1:0]              r_k;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic [psu_pkg::PHASE_BITS-1:0] r_out_phase;
    logic                          r_out_last;
    logic                          r_out_obe;

    logic signed [SAMPLE_BITS-1:0] r_window [KERNEL_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic signed [COEF_BITS-1:0]   r_coef;
    psu_pkg::t_mac_ctl             r_mac_ctl;

    logic                          in_accept;
    logic                          out_free;
    logic [PTR_W-1:0]              wp_next;
    logic [FILL_W-1:0]             fill_next;
    logic                          win_full;
    logic                          trail_due;
    logic [PTR_W-1:0]              rd_addr;
    logic                          mac_done;
    logic signed [SAMPLE_BITS-1:0] mac_result;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign wp_next   = wrap_ptr(r_wp, 1);
    assign fill_next = (r_fill < FILL_W'(KERNEL_TAPS)) ? r_fill + 1'b1 : r_fill;
    assign win_full  = (fill_next == FILL_W'(KERNEL_TAPS));
    assign trail_due = i_in.block_end && (fill_next >= FILL_W'(KERNEL_TAPS - 1));
    assign rd_addr   = (r_state == S_MAC) ? r_rp : r_dir_addr;

    // Sequencer: one input at a time, one result at a time into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_ph        <= '0;
            r_trail     <= 1'b0;
            r_res_last  <= 1'b0;
            r_res_obe   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop a result the receiver has taken, unless a new one replaces it
            if (o_out.ready && !((r_state == S_PUSH) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (UPSAMPLE_FACTOR == 1) begin
                            r_res      <= i_in.in_sample;
                            r_ph       <= '0;
                            r_res_last <= 1'b1;
                            r_res_obe  <= i_in.block_end;
                            r_state    <= S_PUSH;
                        end else begin
                            r_wp      <= wp_next;
                            r_fill    <= i_in.block_end ? '0 : fill_next;
                            r_trail   <= trail_due;
                            r_ph      <= '0;
                            if (win_full) begin
                                r_dir_addr <= wrap_ptr(wp_next, KERNEL_TAPS / 2 - 1);
                                r_res_last <= 1'b0;
                                r_res_obe  <= 1'b0;
                                r_state    <= S_READ;
                            end else if (trail_due) begin
                                r_dir_addr <= wrap_ptr(wp_next, KERNEL_TAPS / 2);
                                r_res_last <= 1'b1;
                                r_res_obe  <= 1'b1;
                                r_state    <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_res   <= r_rd_data;
                    r_state <= S_PUSH;
                end
                S_MAC: begin
                    // advance through the window, oldest sample first
                    r_rp    <= wrap_ptr(r_rp, 1);
                    r_caddr <= r_caddr + CADDR_W'(UPSAMPLE_FACTOR);
                    r_k     <= r_k + 1'b1;
                    if (r_k == PTR_W'(KERNEL_TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (mac_done) begin
                        r_res   <= mac_result;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_res;
                        r_out_phase  <= psu_pkg::PHASE_BITS'(r_ph);
                        r_out_last   <= r_res_last;
                        r_out_obe    <= r_res_obe;
                        if (r_res_last) begin
                            r_state <= S_IDLE;
                        end else if (r_ph != PH_W'(UPSAMPLE_FACTOR - 1)) begin
                            // next filter phase uses kernel L-1-r_ph
                            r_ph       <= r_ph + 1'b1;
                            r_rp       <= r_wp;
                            r_k        <= '0;
                            r_caddr    <= CADDR_W'(UPSAMPLE_FACTOR - 1) - CADDR_W'(r_ph);
                            r_res_last <= (r_ph == PH_W'(UPSAMPLE_FACTOR - 2)) && !r_trail;
                            r_state    <= S_MAC;
                        end else begin
                            // trailing original sample at a block end
                            r_dir_addr <= wrap_ptr(r_wp, KERNEL_TAPS / 2);
                            r_ph       <= '0;
                            r_res_last <= 1'b1;
                            r_res_obe  <= 1'b1;
                            r_state    <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Window memory: write on request, registered read every cycle; kernel table read
    always_ff @(posedge i_clk) begin
        if (in_accept && (UPSAMPLE_FACTOR > 1)) begin
            r_window[r_wp] <= i_in.in_sample;
        end
        r_rd_data <= r_window[rd_addr];
        if (r_state == S_MAC) begin
            r_coef <= COEF_ROM[r_caddr];
        end
    end

    // Tag each operand pair for the MAC, aligned with the registered reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_ctl <= '0;
        end else begin
            r_mac_ctl.valid <= (r_state == S_MAC);
            r_mac_ctl.clear <= (r_k == '0);
            r_mac_ctl.last  <= (r_k == PTR_W'(KERNEL_TAPS - 1));
        end
    end

    psu_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .KERNEL_TAPS (KERNEL_TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_mac_ctl),
        .i_sample (r_rd_data),
        .i_coef   (r_coef),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.out_sample       = r_out_sample;
    assign o_out.phase            = r_out_phase;
    assign o_out.run_last         = r_out_last;
    assign o_out.output_block_end = r_out_obe;

endmodule

`default_nettype wire

/* test/polyphase_sinc_upsampler_unit_test.sv */
// Self-checking testbench for the polyphase sinc upsampler: driver, monitor and predictor
`timescale 1ns / 1ps

module polyphase_sinc_upsampler_unit_test;

    localparam int UPS      = 4;
    localparam int TAPS     = 16;
    localparam int SB       = 24;
    localparam int CB       = 18;
    localparam int FULL_LEN = UPS * TAPS;
    localparam int FRAC     = CB - 2;
    localparam int SH       = 30 - FRAC;

    // Q2.30 values for the kernel table
    localparam logic [63:0] ONE_Q30  = 64'd1073741824;
    localparam logic [63:0] HALF_PI  = 64'd1686629713;
    localparam longint      INV_PI   = 64'sd341782638;
    localparam longint      W_C042   = 64'sd450971566;
    localparam longint      W_C008   = 64'sd85899346;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam int SAT_KERNEL = UPS / 2;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic signed [SB-1:0] sample;
        logic                 blk_end;
    } t_sample_req;

    typedef struct packed {
        logic signed [SB-1:0]                sample;
        logic [psu_pkg::PHASE_BITS-1:0]      phase;
        logic                                run_last;
        logic                                blk_end;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psu_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    psu_out_if #(.SAMPLE_BITS(SB)) out_ch ();

    polyphase_sinc_upsampler_unit #(
        .UPSAMPLE_FACTOR(UPS),
        .KERNEL_TAPS    (TAPS),
        .SAMPLE_BITS    (SB),
        .COEF_BITS      (CB)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    longint               kernel_table [UPS][TAPS];
    logic signed [SB-1:0] history [TAPS];
    int                   history_wr;
    int                   history_fill;
    t_result              expected_results [$];
    t_sample_req          pending_samples [$];

    int send_idle_pct;
    int recv_stall_pct;
    int n_queued;
    int n_accepted;
    int n_results;
    int n_blocks;
    int n_errors;

    // Sign-magnitude Q30 product, magnitude rounded half up
    function automatic longint q30_product(input longint a, input longint b);
        logic        neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] p;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        p   = (ua * ub + (64'd1 << 29)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // Sine of x / 2^32 turns in Q30 via Horner series on a quarter wave
    function automatic longint turn_sine(input logic [31:0] x);
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        r = {34'd0, x[29:0]};
        if (x[30]) begin
            r = 64'h4000_0000 - r;
        end
        a  = (r * HALF_PI) >> 30;
        a2 = (a * a) >> 30;
        t  = ONE_Q30 - a2 / 64'd110;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd6;
        s  = (a * t) >> 30;
        return x[31] ? -longint'(s) : longint'(s);
    endfunction

    // Build the Blackman-windowed sinc and split it into polyphase kernels
    function automatic void build_kernels();
        longint      m;
        longint      sinc;
        longint      s;
        longint      c1;
        longint      c2;
        longint      w;
        longint      c;
        longint      val;
        logic [63:0] um;
        logic [63:0] den;
        logic [63:0] x;
        logic [63:0] x1;
        logic [63:0] x2;
        logic [63:0] mag;
        longint      cmax;
        cmax = (longint'(1) <<< (CB - 1)) - 1;
        for (int t = 0; t < FULL_LEN; t++) begin
            m  = longint'(t) - longint'(FULL_LEN / 2);
            um = (m < 0) ? 64'(-m) : 64'(m);
            if (um == 0) begin
                sinc = longint'(ONE_Q30);
            end else begin
                den  = 64'(2 * UPS);
                x    = (((um % den) << 32) + 64'(UPS)) / den;
                s    = turn_sine(x[31:0]);
                sinc = q30_product((s * UPS) / longint'(um), INV_PI);
            end
            x1  = ((64'(t) << 32) + 64'(FULL_LEN / 2)) / 64'(FULL_LEN);
            x2  = (((64'(2 * t) % 64'(FULL_LEN)) << 32) + 64'(FULL_LEN / 2)) / 64'(FULL_LEN);
            c1  = turn_sine(32'(x1 + 64'h4000_0000));
            c2  = turn_sine(32'(x2 + 64'h4000_0000));
            w   = W_C042 - c1 / 2 + q30_product(W_C008, c2);
            c   = q30_product(sinc, w);
            mag = (c < 0) ? 64'(-c) : 64'(c);
            mag = (mag + (64'd1 << (SH - 1))) >> SH;
            val = (c < 0) ? -longint'(mag) : longint'(mag);
            if (val > cmax) begin
                val = cmax;
            end
            if (val < -cmax - 1) begin
                val = -cmax - 1;
            end
            kernel_table[t % UPS][t / UPS] = val;
        end
    endfunction

    // Correlate the window, oldest first, with one kernel; round and saturate
    function automatic logic signed [SB-1:0] phase_sum(input int kidx);
        longint acc;
        longint q;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(history[(history_wr + k) % TAPS]) * kernel_table[kidx][k];
        end
        q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (q > longint'(S_MAX)) begin
            q = longint'(S_MAX);
        end
        if (q < longint'(S_MIN)) begin
            q = longint'(S_MIN);
        end
        return SB'(q);
    endfunction

    // Advance the window by one sample and queue the results it causes
    function automatic void interpolate_sample(input logic signed [SB-1:0] s,
                                               input logic be);
        t_result batch [$];
        t_result r;
        if (UPS == 1) begin
            r = '{sample: s, phase: '0, run_last: 1'b1, blk_end: be};
            expected_results.push_back(r);
            return;
        end
        history[history_wr] = s;
        history_wr = (history_wr + 1 >= TAPS) ? 0 : history_wr + 1;
        if (history_fill < TAPS) begin
            history_fill++;
        end
        if (history_fill >= TAPS) begin
            for (int i = 0; i < UPS; i++) begin
                r.sample   = (i == 0) ? history[(history_wr + TAPS / 2 - 1) % TAPS]
                                      : phase_sum(UPS - i);
                r.phase    = psu_pkg::PHASE_BITS'(i);
                r.run_last = 1'b0;
                r.blk_end  = 1'b0;
                batch.push_back(r);
            end
        end
        if (be) begin
            // trailing original sample closes the output block
            if (history_fill + 1 >= TAPS) begin
                r = '{sample: history[(history_wr + TAPS / 2) % TAPS], phase: '0,
                      run_last: 1'b0, blk_end: 1'b1};
                batch.push_back(r);
            end
            history_fill = 0;
        end
        if (batch.size() > 0) begin
            batch[batch.size() - 1].run_last = 1'b1;
        end
        foreach (batch[i]) begin
            expected_results.push_back(batch[i]);
        end
    endfunction

    function automatic logic signed [SB-1:0] draw_sample();
        logic signed [SB-1:0] v;
        case ($urandom_range(9))
            0: v = S_MAX;
            1: v = S_MIN;
            default: v = SB'($urandom());
        endcase
        return v;
    endfunction

    function automatic void queue_sample(input logic signed [SB-1:0] s, input logic be);
        t_sample_req req;
        req.sample  = s;
        req.blk_end = be;
        pending_samples.push_back(req);
        n_queued++;
        if (be) begin
            n_blocks++;
        end
    endfunction

    // Mostly blocks long enough to fill the window; some short and just-short ones
    task automatic queue_random_blocks(input int budget);
        int len;
        int used;
        used = 0;
        while (used < budget) begin
            case ($urandom_range(7))
                0: len = $urandom_range(1, TAPS - 2);
                1: len = TAPS - 1;
                default: len = $urandom_range(TAPS, TAPS + 10);
            endcase
            for (int i = 0; i < len; i++) begin
                queue_sample(draw_sample(), i == len - 1);
            end
            used += len;
        end
    endtask

    // Hold until every queued request is taken and every result has come back
    task automatic drain();
        while (n_accepted != n_queued) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: present requests from the pending queue, hold until taken
    always @(posedge i_clk) begin : drive_proc
        logic        take;
        t_sample_req req;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            take = in_ch.valid && in_ch.ready;
            if (take) begin
                interpolate_sample(in_ch.in_sample, in_ch.block_end);
                n_accepted++;
            end
            if (!in_ch.valid || take) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_samples.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.in_sample <= req.sample;
                    in_ch.block_end <= req.blk_end;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation, stall at random
    always @(posedge i_clk) begin : watch_proc
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{sample: out_ch.out_sample, phase: out_ch.phase,
                        run_last: out_ch.run_last, blk_end: out_ch.output_block_end};
                n_results++;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result: sample %0d phase %0d run_last %0b end %0b",
                             $time, got.sample, got.phase, got.run_last, got.blk_end);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        $display("%0t: mismatch: expected sample %0d phase %0d run_last %0b end %0b",
                                 $time, want.sample, want.phase, want.run_last, want.blk_end);
                        $display("%0t:           got sample %0d phase %0d run_last %0b end %0b",
                                 $time, got.sample, got.phase, got.run_last, got.blk_end);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus and end of run
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.in_sample = '0;
        in_ch.block_end = 1'b0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        history_wr      = 0;
        history_fill    = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        n_queued        = 0;
        n_accepted      = 0;
        n_results       = 0;
        n_blocks        = 0;
        n_errors        = 0;
        build_kernels();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a short block that yields nothing, at both sample extremes
        queue_sample(S_MAX, 1'b0);
        queue_sample(S_MIN, 1'b1);
        // Directed: a full window whose signs follow one kernel, driving that phase
        // into saturation, ended at once so the trailing sample follows
        for (int k = 0; k < TAPS; k++) begin
            queue_sample((kernel_table[SAT_KERNEL][k] >= 0) ? S_MAX : S_MIN, k == TAPS - 1);
        end
        // Directed: one sample short of a window, giving only the trailing sample
        for (int k = 0; k < TAPS - 1; k++) begin
            queue_sample((k % 3 == 0) ? SB'(-1) : ((k % 3 == 1) ? SB'(1) : '0),
                         k == TAPS - 2);
        end
        drain();

        // Random blocks under four handshake pressures
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            queue_random_blocks(12);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end

        $display("Covered %0d input samples in %0d blocks, checking %0d results,",
                 n_accepted, n_blocks, n_results);
        $display("with short, one-short and saturating blocks under idle and stall phases.");
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("Timeout waiting for requests or results");
        $display("Some tests failed");
        $finish;
    end

endmodule
